FILE: hdl/go_back_n_sender_fast_retransmit_assert.svh
// Assertion macros used by the checker file.
`ifndef GO_BACK_N_SENDER_FAST_RETRANSMIT_ASSERT_SVH
`define GO_BACK_N_SENDER_FAST_RETRANSMIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("gbn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GBN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("gbn assertion failed");

`endif

FILE: hdl/gbn_pkg.sv
package gbn_pkg;

  localparam int SEQ_W         = 4;
  localparam int SEQ_COUNT     = 1 << SEQ_W;
  localparam int DUP_THRESHOLD = 3;
  localparam int DUP_W         = 2;
  localparam int WIN_W         = 4;
  localparam int TC_W          = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  localparam logic [WIN_W-1:0] WIN_RESET   = WIN_W'(4);
  localparam logic [TC_W-1:0]  LIMIT_RESET = TC_W'(10);

  // input operation codes
  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // result action codes
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_XMIT   = 2'd1;
  localparam logic [1:0] ACT_REFUSE = 2'd2;
  localparam logic [1:0] ACT_ABORT  = 2'd3;

  // timer commands
  localparam logic [1:0] TMR_LEAVE = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RETX_LIMIT  = CFG_IDX_W'(1);

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic load_burst;
  } dp_cmd_t;

  typedef struct packed {
    logic burst_start;
    logic burst_end;
  } dp_stat_t;

endpackage

FILE: hdl/go_back_n_sender_fast_retransmit.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    operation, ack_seq, ack_checksum_ok
// out_      output     out_valid / out_ready  action, seq, timer_cmd, last
// cfg_      input      cfg_valid / cfg_ready  index (0 window_size, 1 retransmit_limit), data
//
// Data offers and acks give one result each; a new input is taken in every
// cycle while the output register is empty or being drained.
// A timeout with N slots outstanding, below the retransmit limit, gives N results, one per
// cycle while out_ready is high, all but the first from the burst counter in the datapath;
// no input is taken until the last is loaded. Reset is synchronous; cfg_ready is always high.
// A stall on out_ready holds the output register and blocks new input.
module go_back_n_sender_fast_retransmit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_operation,
  input  logic [gbn_pkg::SEQ_W-1:0]        in_ack_seq,
  input  logic                             in_ack_checksum_ok,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_action,
  output logic [gbn_pkg::SEQ_W-1:0]        out_seq,
  output logic [1:0]                       out_timer_cmd,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gbn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gbn_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_operation       (in_operation),
    .in_ack_seq         (in_ack_seq),
    .in_ack_checksum_ok (in_ack_checksum_ok),
    .cmd                (cmd),
    .stat               (stat),
    .out_action         (out_action),
    .out_seq            (out_seq),
    .out_timer_cmd      (out_timer_cmd),
    .out_last           (out_last)
  );

endmodule

FILE: hdl/gbn_ctrl.sv
module gbn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gbn_pkg::dp_stat_t stat,
  output gbn_pkg::dp_cmd_t  cmd
);
  import gbn_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;
  logic        accept;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && stat.burst_start) state_nxt = ST_BURST;
      end
      ST_BURST: begin
        if (slot_free && stat.burst_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load_in    = accept;
    cmd.load_burst = (state_r == ST_BURST) && slot_free;
    if (cmd.load_in || cmd.load_burst) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/gbn_dp.sv
module gbn_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]                       in_operation,
  input  logic [gbn_pkg::SEQ_W-1:0]        in_ack_seq,
  input  logic                             in_ack_checksum_ok,
  input  gbn_pkg::dp_cmd_t                 cmd,
  output gbn_pkg::dp_stat_t                stat,
  output logic [1:0]                       out_action,
  output logic [gbn_pkg::SEQ_W-1:0]        out_seq,
  output logic [1:0]                       out_timer_cmd,
  output logic                             out_last
);
  import gbn_pkg::*;

  // configuration
  logic [WIN_W-1:0] win_size_r;
  logic [TC_W-1:0]  retx_limit_r;

  // protocol state
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [SEQ_W-1:0] next_r, next_nxt;
  logic [DUP_W-1:0] dup_r, dup_nxt;
  logic [SEQ_W-1:0] fas_r, fas_nxt;
  logic             fav_r, fav_nxt;
  logic [TC_W-1:0]  tc_r, tc_nxt;
  logic             abort_r, abort_nxt;

  // timeout burst
  logic [SEQ_W-1:0] burst_seq_r;
  logic [SEQ_W-1:0] burst_left_r;

  // result registers
  logic [1:0]       act_r;
  logic [SEQ_W-1:0] seq_r;
  logic [1:0]       tmr_r;
  logic             last_r;

  logic [1:0]       res_act;
  logic [SEQ_W-1:0] res_seq;
  logic [1:0]       res_tmr;
  logic             res_last;

  logic [SEQ_W-1:0] outstanding;
  logic [SEQ_W-1:0] ack_dist;
  logic [SEQ_W-1:0] ack_plus1;
  logic [WIN_W-1:0] eff_win;
  logic [DUP_W-1:0] dup_inc;
  logic [TC_W-1:0]  tc_inc;
  logic             dup_hit;

  assign outstanding = next_r - base_r;
  assign ack_dist    = in_ack_seq - base_r;
  assign ack_plus1   = in_ack_seq + SEQ_W'(1);
  assign dup_inc     = dup_r + DUP_W'(1);
  assign tc_inc      = (tc_r == '1) ? tc_r : tc_r + TC_W'(1);
  assign dup_hit     = (outstanding != '0) && (ack_plus1 == base_r) &&
                       !(fav_r && (in_ack_seq == fas_r));

  always_comb begin
    if (win_size_r == '0) begin
      eff_win = WIN_W'(1);
    end else if (win_size_r > WIN_W'(SEQ_COUNT - 1)) begin
      eff_win = WIN_W'(SEQ_COUNT - 1);
    end else begin
      eff_win = win_size_r;
    end
  end

  always_comb begin
    res_act          = ACT_NONE;
    res_seq          = '0;
    res_tmr          = TMR_LEAVE;
    res_last         = 1'b1;
    base_nxt         = base_r;
    next_nxt         = next_r;
    dup_nxt          = dup_r;
    fas_nxt          = fas_r;
    fav_nxt          = fav_r;
    tc_nxt           = tc_r;
    abort_nxt        = abort_r;
    stat.burst_start = 1'b0;
    stat.burst_end   = (burst_left_r == SEQ_W'(1));
    if (abort_r) begin
      res_act = ACT_ABORT;
    end else begin
      case (in_operation)
        OP_DATA: begin
          if (outstanding < eff_win) begin
            res_act  = ACT_XMIT;
            res_seq  = next_r;
            res_tmr  = (outstanding == '0) ? TMR_START : TMR_LEAVE;
            next_nxt = next_r + SEQ_W'(1);
          end else begin
            res_act = ACT_REFUSE;
          end
        end
        OP_ACK: begin
          tc_nxt = '0;
          if (in_ack_checksum_ok) begin
            if (ack_dist < outstanding) begin
              base_nxt = ack_plus1;
              dup_nxt  = '0;
              res_tmr  = (ack_plus1 == next_r) ? TMR_STOP : TMR_START;
            end else if (dup_hit) begin
              if (dup_inc >= DUP_W'(DUP_THRESHOLD)) begin
                dup_nxt = '0;
                fas_nxt = in_ack_seq;
                fav_nxt = 1'b1;
                res_act = ACT_XMIT;
                res_seq = base_r;
                res_tmr = TMR_START;
              end else begin
                dup_nxt = dup_inc;
              end
            end
          end
        end
        OP_TIMEOUT: begin
          if (outstanding != '0) begin
            tc_nxt = tc_inc;
            if (tc_inc >= retx_limit_r) begin
              abort_nxt = 1'b1;
              res_act   = ACT_ABORT;
              res_tmr   = TMR_STOP;
            end else begin
              // first retransmit now, the rest of the window follows
              res_act          = ACT_XMIT;
              res_seq          = base_r;
              res_tmr          = TMR_START;
              res_last         = (outstanding == SEQ_W'(1));
              stat.burst_start = (outstanding != SEQ_W'(1));
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r   <= WIN_RESET;
      retx_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_SIZE: win_size_r   <= cfg_data[WIN_W-1:0];
        CFG_RETX_LIMIT:  retx_limit_r <= cfg_data[TC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      next_r  <= '0;
      dup_r   <= '0;
      fas_r   <= '0;
      fav_r   <= 1'b0;
      tc_r    <= '0;
      abort_r <= 1'b0;
    end else if (cmd.load_in) begin
      base_r  <= base_nxt;
      next_r  <= next_nxt;
      dup_r   <= dup_nxt;
      fas_r   <= fas_nxt;
      fav_r   <= fav_nxt;
      tc_r    <= tc_nxt;
      abort_r <= abort_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r        <= res_act;
      seq_r        <= res_seq;
      tmr_r        <= res_tmr;
      last_r       <= res_last;
      burst_seq_r  <= base_r + SEQ_W'(1);
      burst_left_r <= outstanding - SEQ_W'(1);
    end else if (cmd.load_burst) begin
      act_r        <= ACT_XMIT;
      seq_r        <= burst_seq_r;
      tmr_r        <= TMR_LEAVE;
      last_r       <= stat.burst_end;
      burst_seq_r  <= burst_seq_r + SEQ_W'(1);
      burst_left_r <= burst_left_r - SEQ_W'(1);
    end
  end

  assign out_action    = act_r;
  assign out_seq       = seq_r;
  assign out_timer_cmd = tmr_r;
  assign out_last      = last_r;

endmodule

FILE: hdl/gbn_checker.sv
`include "go_back_n_sender_fast_retransmit_assert.svh"

module gbn_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [1:0]                       out_action,
  input logic [gbn_pkg::SEQ_W-1:0]        out_seq,
  input logic [1:0]                       out_timer_cmd,
  input logic                             out_last
);
  import gbn_pkg::*;

  logic [SEQ_W+4:0] out_bus;
  logic             burst_more;
  logic             burst_xmit;
  logic             non_xmit;

  assign out_bus    = {out_action, out_seq, out_timer_cmd, out_last};
  assign burst_more = out_valid && out_ready && !out_last;
  assign burst_xmit = (out_action == ACT_XMIT) && (out_timer_cmd == TMR_LEAVE);
  assign non_xmit   = out_valid && (out_action != ACT_XMIT);

  // a stalled result holds
  `GBN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bus))

  // no new transaction while a retransmit burst is still going out
  `GBN_ASSERT_NOW(a_no_accept_in_burst, clk, rst_n, out_valid && !out_last, !in_ready)

  // burst results follow back to back as retransmits
  `GBN_ASSERT_NEXT(a_burst_follows, clk, rst_n, burst_more, out_valid && burst_xmit)

  // only transmit orders come in bursts or name a slot
  `GBN_ASSERT_NOW(a_single_non_xmit, clk, rst_n, non_xmit, out_last && (out_seq == '0))

endmodule

bind go_back_n_sender_fast_retransmit gbn_checker u_gbn_checker (.*);
